### rtl/a64enc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// a64enc_pkg
// Kinds, status codes, base opcodes and range helper shared by the
// instruction encoder and its checker.
// ---------------------------------------------------------------------------
package a64enc_pkg;

    localparam int unsigned KIND_W   = 5;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned S_DATA_W = 168;
    localparam int unsigned M_DATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADR      = 5'd0,
        KIND_ADRP     = 5'd1,
        KIND_BR       = 5'd2,
        KIND_LDP_IDX  = 5'd3,
        KIND_LDP_OFF  = 5'd4,
        KIND_STP_IDX  = 5'd5,
        KIND_STP_OFF  = 5'd6,
        KIND_NOP      = 5'd7,
        KIND_RET      = 5'd8,
        KIND_MOV      = 5'd9,
        KIND_CCMP     = 5'd10,
        KIND_ADD_IMM  = 5'd11,
        KIND_BL       = 5'd12,
        KIND_B        = 5'd13,
        KIND_BCOND    = 5'd14,
        KIND_CBZ      = 5'd15,
        KIND_MOVZ     = 5'd16,
        KIND_MOVK     = 5'd17,
        KIND_LDR_IMM  = 5'd18,
        KIND_TBZ      = 5'd19,
        KIND_LDR_LIT  = 5'd20
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_ALIGN = 3'd2,
        ST_PAC   = 3'd3,
        ST_KIND  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PAC_PLAIN = 3'd0,
        PAC_AA    = 3'd1,
        PAC_AAZ   = 3'd2,
        PAC_AB    = 3'd3,
        PAC_ABZ   = 3'd4
    } pac_t;

    localparam logic [31:0] OP_NOP     = 32'hD503_201F;
    localparam logic [31:0] OP_RET     = 32'hD65F_03C0;
    localparam logic [31:0] OP_ADR     = 32'h1000_0000;
    localparam logic [31:0] OP_ADRP    = 32'h9000_0000;
    localparam logic [31:0] OP_BR      = 32'hD61F_0000;
    localparam logic [31:0] OP_LDRL    = 32'h5800_0000;
    localparam logic [31:0] OP_LDP_IDX = 32'hA8C0_0000;
    localparam logic [31:0] OP_LDP_OFF = 32'hA940_0000;
    localparam logic [31:0] OP_STP_IDX = 32'hA880_0000;
    localparam logic [31:0] OP_STP_OFF = 32'hA900_0000;
    localparam logic [31:0] OP_MOV     = 32'hAA00_0000;
    localparam logic [31:0] OP_CCMP    = 32'hFA40_0000;
    localparam logic [31:0] OP_ADD_IMM = 32'h1100_0000;
    localparam logic [31:0] OP_BL      = 32'h9400_0000;
    localparam logic [31:0] OP_B       = 32'h1400_0000;
    localparam logic [31:0] OP_BCOND   = 32'h5400_0000;
    localparam logic [31:0] OP_CBZ     = 32'hB400_0000;
    localparam logic [31:0] OP_MOVZ    = 32'hD280_0000;
    localparam logic [31:0] OP_MOVK    = 32'hF280_0000;
    localparam logic [31:0] OP_LDR_IMM = 32'hF940_0000;
    localparam logic [31:0] OP_TBZ     = 32'h3600_0000;

    localparam logic [31:0] BR_PAC_BIT  = 32'h0000_0800;
    localparam logic [31:0] BR_KEYB_BIT = 32'h0000_0400;
    localparam logic [31:0] BR_MOD_BIT  = 32'h0100_0000;

    // true when v, as two's complement, fits a signed field of the given width
    function automatic logic fits_signed(input logic [63:0] v, input int unsigned bits);
        logic signed [63:0] hi;
        hi = $signed(v) >>> (bits - 1);
        return (hi == '0) || (hi == '1);
    endfunction

endpackage

### rtl/arm64_instruction_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arm64_instruction_encoder
// Builds one A64 instruction word and a status from a kind and its operands.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready with the instruction kind on
//   s_tuser and pc, target or immediate, registers and small fields packed in
//   s_tdata. Each input word gives exactly one result word on m_tvalid/
//   m_tready: the instruction in m_tdata[31:0] and the status in
//   m_tdata[34:32]; the instruction is zero whenever the status is not ok.
//   Between acceptance and m_tvalid a word passes offset subtraction, then
//   range and alignment checks, then field packing into the output register.
//   Throughput is one word per cycle while the receiver takes results; each stage carries its own valid bit.
//   When the receiver stalls, the output word holds and stages behind it
//   keep filling until the pipeline is full, then s_tready drops; nothing is
//   lost or repeated. Reset (aresetn low at a clock edge) empties every stage
//   and the block is ready on the next cycle.
// ---------------------------------------------------------------------------
module arm64_instruction_encoder
    import a64enc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pc, operand_value, reg_d, reg_n, reg_m, condition_code, nzcv_flags,
    // pac_mode, variant_bit, small_field, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // kind
    input  logic [KIND_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // instruction_word, status, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    typedef struct packed {
        logic [4:0] reg_d;
        logic [4:0] reg_n;
        logic [4:0] reg_m;
        logic [3:0] cond;
        logic [3:0] nzcv;
        logic [2:0] pac;
        logic       var_bit;
        logic [5:0] field6;
    } opnd_t;

    logic        s1_ready;
    logic        s2_ready;
    logic        out_ready;

    logic        s1_valid_reg;
    kind_t       s1_kind_reg;
    logic [63:0] s1_val_reg;
    logic [63:0] s1_diff_reg;
    logic [52:0] s1_page_reg;
    opnd_t       s1_opnd_reg;

    logic [63:0] in_pc;
    logic [63:0] in_val;
    opnd_t       in_opnd;
    logic [63:0] diff_next;
    logic [52:0] page_next;

    logic        s2_valid_reg;
    kind_t       s2_kind_reg;
    status_t     s2_status_reg;
    logic [27:0] s2_diff_reg;
    logic [20:0] s2_page_reg;
    logic [23:0] s2_val_reg;
    opnd_t       s2_opnd_reg;
    status_t     status_next;

    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    status_t     out_status_reg;
    logic [31:0] word_next;

    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;

    assign in_pc   = s_tdata[63:0];
    assign in_val  = s_tdata[127:64];
    assign in_opnd = '{
        reg_d:   s_tdata[132:128],
        reg_n:   s_tdata[137:133],
        reg_m:   s_tdata[142:138],
        cond:    s_tdata[146:143],
        nzcv:    s_tdata[150:147],
        pac:     s_tdata[153:151],
        var_bit: s_tdata[154],
        field6:  s_tdata[160:155]
    };

    assign diff_next = in_val - in_pc;
    assign page_next = {1'b0, in_val[63:12]} - {1'b0, in_pc[63:12]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1: offsets
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_kind_reg <= kind_t'(s_tuser);
            s1_val_reg  <= in_val;
            s1_diff_reg <= diff_next;
            s1_page_reg <= page_next;
            s1_opnd_reg <= in_opnd;
        end
    end

    // stage 2: range, alignment, pac mode and kind checks
    always_comb begin
        status_next = ST_OK;
        case (s1_kind_reg)
            KIND_ADR: begin
                if (!fits_signed(s1_diff_reg, 21)) status_next = ST_RANGE;
            end
            KIND_ADRP: begin
                if (s1_val_reg[11:0] != 12'd0) begin
                    status_next = ST_ALIGN;
                end else if (!fits_signed({{11{s1_page_reg[52]}}, s1_page_reg}, 21)) begin
                    status_next = ST_RANGE;
                end
            end
            KIND_BR: begin
                if (s1_opnd_reg.pac > PAC_ABZ) status_next = ST_PAC;
            end
            KIND_LDP_IDX, KIND_LDP_OFF, KIND_STP_IDX, KIND_STP_OFF: begin
                if (!fits_signed(s1_val_reg, 7)) status_next = ST_RANGE;
            end
            KIND_NOP, KIND_RET, KIND_MOV, KIND_CCMP, KIND_MOVZ, KIND_MOVK: begin
                status_next = ST_OK;
            end
            KIND_ADD_IMM: begin
                if (s1_val_reg[11:0] == 12'd0) begin
                    if (s1_val_reg[63:24] != 40'd0) status_next = ST_RANGE;
                end else if (s1_val_reg[63:12] != 52'd0) begin
                    status_next = ST_RANGE;
                end
            end
            KIND_BL, KIND_B: begin
                if (s1_diff_reg[1:0] != 2'd0) begin
                    status_next = ST_ALIGN;
                end else if (!fits_signed(s1_diff_reg, 28)) begin
                    status_next = ST_RANGE;
                end
            end
            KIND_BCOND: begin
                if (s1_diff_reg[1:0] != 2'd0) begin
                    status_next = ST_ALIGN;
                end else if (!fits_signed(s1_diff_reg, 21)) begin
                    status_next = ST_RANGE;
                end
            end
            KIND_CBZ: begin
                if (!fits_signed(s1_val_reg, 19)) status_next = ST_RANGE;
            end
            KIND_LDR_IMM: begin
                if (s1_val_reg[2:0] != 3'd0) begin
                    status_next = ST_ALIGN;
                end else if (s1_val_reg[63:15] != 49'd0) begin
                    status_next = ST_RANGE;
                end
            end
            KIND_TBZ: begin
                if (!fits_signed(s1_val_reg, 14)) status_next = ST_RANGE;
            end
            KIND_LDR_LIT: begin
                if (!fits_signed(s1_diff_reg, 21)) begin
                    status_next = ST_RANGE;
                end else if (s1_diff_reg[1:0] != 2'd0) begin
                    status_next = ST_ALIGN;
                end
            end
            default: begin
                status_next = ST_KIND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_kind_reg   <= s1_kind_reg;
            s2_status_reg <= status_next;
            s2_diff_reg   <= s1_diff_reg[27:0];
            s2_page_reg   <= s1_page_reg[20:0];
            s2_val_reg    <= s1_val_reg[23:0];
            s2_opnd_reg   <= s1_opnd_reg;
        end
    end

    // stage 3: field packing
    always_comb begin
        word_next = 32'd0;
        case (s2_kind_reg)
            KIND_ADR: begin
                word_next = OP_ADR | {1'b0, s2_diff_reg[1:0], 29'd0}
                          | {8'd0, s2_diff_reg[20:2], s2_opnd_reg.reg_d};
            end
            KIND_ADRP: begin
                word_next = OP_ADRP | {1'b0, s2_page_reg[1:0], 29'd0}
                          | {8'd0, s2_page_reg[20:2], s2_opnd_reg.reg_d};
            end
            KIND_BR: begin
                word_next = OP_BR | {22'd0, s2_opnd_reg.reg_n, 5'd0};
                if (s2_opnd_reg.pac != PAC_PLAIN) begin
                    word_next = word_next | BR_PAC_BIT;
                    if (s2_opnd_reg.pac == PAC_AB || s2_opnd_reg.pac == PAC_ABZ) begin
                        word_next = word_next | BR_KEYB_BIT;
                    end
                    if (s2_opnd_reg.pac == PAC_AA || s2_opnd_reg.pac == PAC_AB) begin
                        word_next = word_next | BR_MOD_BIT | {27'd0, s2_opnd_reg.reg_m};
                    end else begin
                        word_next = word_next | 32'd31;
                    end
                end
            end
            KIND_LDP_IDX, KIND_LDP_OFF, KIND_STP_IDX, KIND_STP_OFF: begin
                case (s2_kind_reg)
                    KIND_LDP_IDX: word_next = OP_LDP_IDX | {7'd0, s2_opnd_reg.var_bit, 24'd0};
                    KIND_LDP_OFF: word_next = OP_LDP_OFF;
                    KIND_STP_IDX: word_next = OP_STP_IDX | {7'd0, s2_opnd_reg.var_bit, 24'd0};
                    default:      word_next = OP_STP_OFF;
                endcase
                word_next = word_next | {10'd0, s2_val_reg[6:0], s2_opnd_reg.reg_m,
                                         s2_opnd_reg.reg_n, s2_opnd_reg.reg_d};
            end
            KIND_NOP: begin
                word_next = OP_NOP;
            end
            KIND_RET: begin
                word_next = OP_RET;
            end
            KIND_MOV: begin
                word_next = OP_MOV | {11'd0, s2_opnd_reg.reg_m, s2_opnd_reg.field6,
                                      s2_opnd_reg.reg_n, s2_opnd_reg.reg_d};
            end
            KIND_CCMP: begin
                word_next = OP_CCMP | {11'd0, s2_opnd_reg.reg_m, s2_opnd_reg.cond, 2'd0,
                                       s2_opnd_reg.reg_n, 1'b0, s2_opnd_reg.nzcv};
            end
            KIND_ADD_IMM: begin
                if (s2_val_reg[11:0] == 12'd0) begin
                    word_next = OP_ADD_IMM | {10'd1, s2_val_reg[23:12], s2_opnd_reg.reg_n,
                                              s2_opnd_reg.reg_d};
                end else begin
                    word_next = OP_ADD_IMM | {10'd0, s2_val_reg[11:0], s2_opnd_reg.reg_n,
                                              s2_opnd_reg.reg_d};
                end
            end
            KIND_BL: begin
                word_next = OP_BL | {6'd0, s2_diff_reg[27:2]};
            end
            KIND_B: begin
                word_next = OP_B | {6'd0, s2_diff_reg[27:2]};
            end
            KIND_BCOND: begin
                word_next = OP_BCOND | {8'd0, s2_diff_reg[20:2], 1'b0, s2_opnd_reg.cond};
            end
            KIND_CBZ: begin
                word_next = OP_CBZ | {7'd0, s2_opnd_reg.var_bit, s2_val_reg[18:0],
                                      s2_opnd_reg.reg_d};
            end
            KIND_MOVZ: begin
                word_next = OP_MOVZ | {9'd0, s2_opnd_reg.field6[1:0], s2_val_reg[15:0],
                                       s2_opnd_reg.reg_d};
            end
            KIND_MOVK: begin
                word_next = OP_MOVK | {9'd0, s2_opnd_reg.field6[1:0], s2_val_reg[15:0],
                                       s2_opnd_reg.reg_d};
            end
            KIND_LDR_IMM: begin
                word_next = OP_LDR_IMM | {10'd0, s2_val_reg[14:3], s2_opnd_reg.reg_n,
                                          s2_opnd_reg.reg_d};
            end
            KIND_TBZ: begin
                word_next = OP_TBZ | {s2_opnd_reg.field6[5], 6'd0, s2_opnd_reg.var_bit,
                                      s2_opnd_reg.field6[4:0], s2_val_reg[13:0],
                                      s2_opnd_reg.reg_d};
            end
            KIND_LDR_LIT: begin
                word_next = OP_LDRL | {8'd0, s2_diff_reg[20:2], s2_opnd_reg.reg_d};
            end
            default: begin
                word_next = 32'd0;
            end
        endcase
        if (s2_status_reg != ST_OK) begin
            word_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_word_reg   <= word_next;
            out_status_reg <= s2_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_word_reg};

endmodule

### rtl/a64enc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// a64enc_checker
// Port-level checks on the instruction encoder, bound to its top level.
// ---------------------------------------------------------------------------
module a64enc_checker
    import a64enc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [KIND_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic s_side_seen;

    assign s_side_seen = s_tvalid || (|s_tdata) || (|s_tuser) || 1'b1;

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && s_side_seen) |-> (m_tdata[34:32] <= ST_KIND) && (m_tdata[39:35] == 5'd0))
        else $error("result status outside the defined codes");

    a_error_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34:32] != ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("instruction not cleared on error status");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output is empty");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind arm64_instruction_encoder a64enc_checker u_a64enc_checker (.*);
